### rtl/anpt_pkg.sv
`timescale 1ns / 1ps

package anpt_pkg;

   // Table geometry.
   localparam int MAX_POINTS = 64;
   localparam int COORD_BITS = 16;
   localparam int TAG_BITS   = 16;

   localparam int IDX_BITS   = $clog2(MAX_POINTS);
   localparam int CNT_BITS   = $clog2(MAX_POINTS + 1);
   localparam int ENTRY_BITS = TAG_BITS + 2 * COORD_BITS;
   localparam int DIST_BITS  = COORD_BITS + 1;

   // Operation codes.
   localparam logic [2:0] MODE_ADD      = 3'd0;
   localparam logic [2:0] MODE_REMOVE   = 3'd1;
   localparam logic [2:0] MODE_POSITION = 3'd2;
   localparam logic [2:0] MODE_CELL     = 3'd3;
   localparam logic [2:0] MODE_NEAREST  = 3'd4;

   // Result status codes.
   localparam logic [2:0] STATUS_OK            = 3'd0;
   localparam logic [2:0] STATUS_TAG_EXISTS    = 3'd1;
   localparam logic [2:0] STATUS_CELL_OCCUPIED = 3'd2;
   localparam logic [2:0] STATUS_TAG_MISSING   = 3'd3;
   localparam logic [2:0] STATUS_NONE_IN_DIR   = 3'd4;
   localparam logic [2:0] STATUS_TABLE_FULL    = 3'd5;

   // Direction codes.
   localparam logic [1:0] DIR_NORTH = 2'd0;
   localparam logic [1:0] DIR_SOUTH = 2'd1;
   localparam logic [1:0] DIR_EAST  = 2'd2;
   localparam logic [1:0] DIR_WEST  = 2'd3;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN_KEY,
      ST_DECIDE,
      ST_SCAN_NEAR,
      ST_NEAR_DONE
   } state_type;

   // Compare results for one table entry.
   typedef struct packed {
      logic                        tag_eq;
      logic                        cell_eq;
      logic                        closer;
      logic signed [DIST_BITS-1:0] delta;
   } match_type;

endpackage

### rtl/anpt_ram.sv
`timescale 1ns / 1ps

module anpt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### rtl/anpt_match.sv
`timescale 1ns / 1ps

module anpt_match import anpt_pkg::*; (
   input  logic                         entry_valid,
   input  logic                         is_src,
   input  logic [TAG_BITS-1:0]          entry_tag,
   input  logic signed [COORD_BITS-1:0] entry_x,
   input  logic signed [COORD_BITS-1:0] entry_y,
   input  logic [TAG_BITS-1:0]          key_tag,
   input  logic signed [COORD_BITS-1:0] key_x,
   input  logic signed [COORD_BITS-1:0] key_y,
   input  logic signed [COORD_BITS-1:0] src_x,
   input  logic signed [COORD_BITS-1:0] src_y,
   input  logic [1:0]                   direction,
   input  logic                         best_hit,
   input  logic signed [DIST_BITS-1:0]  best_dist,
   output match_type                    result
);

   logic signed [DIST_BITS-1:0] ex;
   logic signed [DIST_BITS-1:0] ey;
   logic signed [DIST_BITS-1:0] sx;
   logic signed [DIST_BITS-1:0] sy;
   logic signed [DIST_BITS-1:0] delta;
   logic                        on_line;
   logic                        ahead;

   // Signed distance from the source point along the requested direction.
   always_comb begin
      ex = {entry_x[COORD_BITS-1], entry_x};
      ey = {entry_y[COORD_BITS-1], entry_y};
      sx = {src_x[COORD_BITS-1], src_x};
      sy = {src_y[COORD_BITS-1], src_y};
      case (direction)
         DIR_NORTH: begin
            delta   = ey - sy;
            on_line = (entry_x == src_x);
         end
         DIR_SOUTH: begin
            delta   = sy - ey;
            on_line = (entry_x == src_x);
         end
         DIR_EAST: begin
            delta   = ex - sx;
            on_line = (entry_y == src_y);
         end
         default: begin
            delta   = sx - ex;
            on_line = (entry_y == src_y);
         end
      endcase
   end

   // Exact matches against the request key. A nearest candidate must lie
   // strictly beyond the source and beat the best so far.
   always_comb begin
      result.tag_eq  = entry_valid && (entry_tag == key_tag);
      result.cell_eq = entry_valid && (entry_x == key_x) && (entry_y == key_y);
      ahead          = !delta[DIST_BITS-1] && (delta != '0);
      result.delta   = delta;
      result.closer  = entry_valid && !is_src && on_line && ahead &&
                       (!best_hit || (delta < best_dist));
   end

endmodule

### rtl/axis_nearest_point_table.sv
`timescale 1ns / 1ps

// Table of up to MAX_POINTS tagged points on a signed integer grid. An item is
// taken when start is high and busy is low; its one result appears on the rsp_
// ports for exactly one cycle, marked by rsp_strobe, and cannot be held off.
// Every item walks the whole table once through a single-port read of the
// entry memory, one entry per cycle: add, remove, position and cell queries
// then return their result, and busy falls in the cycle the result is shown,
// so a new item may be started then. A nearest query whose tag is found walks
// the table a second time, measuring against the point found on the first pass.
// No clearing pass is needed after reset: the occupied flags are flip-flops.

module axis_nearest_point_table import anpt_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [2:0]                   req_mode,
   input  logic [TAG_BITS-1:0]          req_tower_tag,
   input  logic signed [COORD_BITS-1:0] req_x_coord,
   input  logic signed [COORD_BITS-1:0] req_y_coord,
   input  logic [1:0]                   req_direction,
   output logic                         rsp_strobe,
   output logic [2:0]                   rsp_status,
   output logic                         rsp_found,
   output logic [TAG_BITS-1:0]          rsp_result_tag,
   output logic signed [COORD_BITS-1:0] rsp_result_x,
   output logic signed [COORD_BITS-1:0] rsp_result_y
);

   localparam logic [CNT_BITS-1:0] SCAN_END = CNT_BITS'(MAX_POINTS);

   // Control state.
   state_type               state_ff, state_in;
   logic [CNT_BITS-1:0]     cnt_ff, cnt_in;
   logic                    chk_vld_ff, chk_vld_in;
   logic [IDX_BITS-1:0]     chk_idx_ff, chk_idx_in;
   logic [MAX_POINTS-1:0]   valid_ff, valid_in;
   logic                    rsp_strobe_ff, rsp_strobe_in;

   // Latched item.
   logic [2:0]                   mode_ff, mode_in;
   logic [TAG_BITS-1:0]          tag_ff, tag_in;
   logic signed [COORD_BITS-1:0] x_ff, x_in;
   logic signed [COORD_BITS-1:0] y_ff, y_in;
   logic [1:0]                   dir_ff, dir_in;

   // Scan findings.
   logic                         tag_hit_ff, tag_hit_in;
   logic [IDX_BITS-1:0]          tag_idx_ff, tag_idx_in;
   logic signed [COORD_BITS-1:0] src_x_ff, src_x_in;
   logic signed [COORD_BITS-1:0] src_y_ff, src_y_in;
   logic                         cell_hit_ff, cell_hit_in;
   logic [TAG_BITS-1:0]          cell_tag_ff, cell_tag_in;
   logic                         free_hit_ff, free_hit_in;
   logic [IDX_BITS-1:0]          free_idx_ff, free_idx_in;
   logic                         best_hit_ff, best_hit_in;
   logic signed [DIST_BITS-1:0]  best_dist_ff, best_dist_in;
   logic [TAG_BITS-1:0]          best_tag_ff, best_tag_in;

   // Result registers.
   logic [2:0]                   rsp_status_ff, rsp_status_in;
   logic                         rsp_found_ff, rsp_found_in;
   logic [TAG_BITS-1:0]          rsp_tag_ff, rsp_tag_in;
   logic signed [COORD_BITS-1:0] rsp_x_ff, rsp_x_in;
   logic signed [COORD_BITS-1:0] rsp_y_ff, rsp_y_in;

   // Memory port and entry fields.
   logic                         rd_en;
   logic                         ram_we;
   logic [ENTRY_BITS-1:0]        ram_rdata;
   logic [TAG_BITS-1:0]          ent_tag;
   logic signed [COORD_BITS-1:0] ent_x;
   logic signed [COORD_BITS-1:0] ent_y;
   logic                         ent_valid;
   logic                         scan_last;
   match_type                    match;

   anpt_ram #(
      .WIDTH(ENTRY_BITS),
      .DEPTH(MAX_POINTS)
   ) u_entry_ram (
      .clock(clock),
      .we   (ram_we),
      .waddr(free_idx_ff),
      .wdata({tag_ff, x_ff, y_ff}),
      .re   (rd_en),
      .raddr(cnt_ff[IDX_BITS-1:0]),
      .rdata(ram_rdata)
   );

   assign ent_tag   = ram_rdata[ENTRY_BITS-1 -: TAG_BITS];
   assign ent_x     = ram_rdata[2*COORD_BITS-1 -: COORD_BITS];
   assign ent_y     = ram_rdata[COORD_BITS-1:0];
   assign ent_valid = valid_ff[chk_idx_ff];
   assign scan_last = chk_vld_ff && (cnt_ff == SCAN_END);

   anpt_match u_match (
      .entry_valid(ent_valid),
      .is_src     (chk_idx_ff == tag_idx_ff),
      .entry_tag  (ent_tag),
      .entry_x    (ent_x),
      .entry_y    (ent_y),
      .key_tag    (tag_ff),
      .key_x      (x_ff),
      .key_y      (y_ff),
      .src_x      (src_x_ff),
      .src_y      (src_y_ff),
      .direction  (dir_ff),
      .best_hit   (best_hit_ff),
      .best_dist  (best_dist_ff),
      .result     (match)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_SCAN_KEY;
            end
         end
         ST_SCAN_KEY: begin
            if (scan_last) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if ((mode_ff == MODE_NEAREST) && tag_hit_ff) begin
               state_in = ST_SCAN_NEAR;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN_NEAR: begin
            if (scan_last) begin
               state_in = ST_NEAR_DONE;
            end
         end
         ST_NEAR_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath and outputs for each state.
   always_comb begin
      rd_en         = 1'b0;
      ram_we        = 1'b0;
      cnt_in        = cnt_ff;
      chk_vld_in    = 1'b0;
      chk_idx_in    = chk_idx_ff;
      valid_in      = valid_ff;
      rsp_strobe_in = 1'b0;
      mode_in       = mode_ff;
      tag_in        = tag_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      dir_in        = dir_ff;
      tag_hit_in    = tag_hit_ff;
      tag_idx_in    = tag_idx_ff;
      src_x_in      = src_x_ff;
      src_y_in      = src_y_ff;
      cell_hit_in   = cell_hit_ff;
      cell_tag_in   = cell_tag_ff;
      free_hit_in   = free_hit_ff;
      free_idx_in   = free_idx_ff;
      best_hit_in   = best_hit_ff;
      best_dist_in  = best_dist_ff;
      best_tag_in   = best_tag_ff;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_tag_in    = rsp_tag_ff;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;

      case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (start) begin
               mode_in     = req_mode;
               tag_in      = req_tower_tag;
               x_in        = req_x_coord;
               y_in        = req_y_coord;
               dir_in      = req_direction;
               tag_hit_in  = 1'b0;
               cell_hit_in = 1'b0;
               free_hit_in = 1'b0;
            end
         end
         ST_SCAN_KEY: begin
            // Issue the next read; check the entry read in the cycle before.
            rd_en = (cnt_ff < SCAN_END);
            if (rd_en) begin
               cnt_in     = cnt_ff + 1'b1;
               chk_vld_in = 1'b1;
               chk_idx_in = cnt_ff[IDX_BITS-1:0];
            end
            if (chk_vld_ff) begin
               if (match.tag_eq && !tag_hit_ff) begin
                  tag_hit_in = 1'b1;
                  tag_idx_in = chk_idx_ff;
                  src_x_in   = ent_x;
                  src_y_in   = ent_y;
               end
               if (match.cell_eq && !cell_hit_ff) begin
                  cell_hit_in = 1'b1;
                  cell_tag_in = ent_tag;
               end
               if (!ent_valid && !free_hit_ff) begin
                  free_hit_in = 1'b1;
                  free_idx_in = chk_idx_ff;
               end
            end
         end
         ST_DECIDE: begin
            cnt_in        = '0;
            best_hit_in   = 1'b0;
            rsp_status_in = STATUS_OK;
            rsp_found_in  = 1'b0;
            rsp_tag_in    = '0;
            rsp_x_in      = '0;
            rsp_y_in      = '0;
            rsp_strobe_in = 1'b1;
            case (mode_ff)
               MODE_ADD: begin
                  if (tag_hit_ff) begin
                     rsp_status_in = STATUS_TAG_EXISTS;
                  end else if (cell_hit_ff) begin
                     rsp_status_in = STATUS_CELL_OCCUPIED;
                  end else if (!free_hit_ff) begin
                     rsp_status_in = STATUS_TABLE_FULL;
                  end else begin
                     ram_we                = 1'b1;
                     valid_in[free_idx_ff] = 1'b1;
                  end
               end
               MODE_REMOVE: begin
                  if (tag_hit_ff) begin
                     valid_in[tag_idx_ff] = 1'b0;
                  end else begin
                     rsp_status_in = STATUS_TAG_MISSING;
                  end
               end
               MODE_POSITION: begin
                  if (tag_hit_ff) begin
                     rsp_x_in = src_x_ff;
                     rsp_y_in = src_y_ff;
                  end else begin
                     rsp_status_in = STATUS_TAG_MISSING;
                  end
               end
               MODE_CELL: begin
                  rsp_found_in = cell_hit_ff;
                  if (cell_hit_ff) begin
                     rsp_tag_in = cell_tag_ff;
                  end
               end
               MODE_NEAREST: begin
                  // A found tag starts the second pass; the result comes later.
                  if (tag_hit_ff) begin
                     rsp_strobe_in = 1'b0;
                  end else begin
                     rsp_status_in = STATUS_TAG_MISSING;
                  end
               end
               default: begin
                  rsp_status_in = STATUS_OK;
               end
            endcase
         end
         ST_SCAN_NEAR: begin
            rd_en = (cnt_ff < SCAN_END);
            if (rd_en) begin
               cnt_in     = cnt_ff + 1'b1;
               chk_vld_in = 1'b1;
               chk_idx_in = cnt_ff[IDX_BITS-1:0];
            end
            if (chk_vld_ff && match.closer) begin
               best_hit_in  = 1'b1;
               best_dist_in = match.delta;
               best_tag_in  = ent_tag;
            end
         end
         ST_NEAR_DONE: begin
            rsp_strobe_in = 1'b1;
            rsp_found_in  = 1'b0;
            rsp_x_in      = '0;
            rsp_y_in      = '0;
            if (best_hit_ff) begin
               rsp_status_in = STATUS_OK;
               rsp_tag_in    = best_tag_ff;
            end else begin
               rsp_status_in = STATUS_NONE_IN_DIR;
               rsp_tag_in    = '0;
            end
         end
         default: begin
            cnt_in = '0;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         chk_vld_ff    <= 1'b0;
         valid_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         chk_vld_ff    <= chk_vld_in;
         valid_ff      <= valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      chk_idx_ff    <= chk_idx_in;
      mode_ff       <= mode_in;
      tag_ff        <= tag_in;
      x_ff          <= x_in;
      y_ff          <= y_in;
      dir_ff        <= dir_in;
      tag_hit_ff    <= tag_hit_in;
      tag_idx_ff    <= tag_idx_in;
      src_x_ff      <= src_x_in;
      src_y_ff      <= src_y_in;
      cell_hit_ff   <= cell_hit_in;
      cell_tag_ff   <= cell_tag_in;
      free_hit_ff   <= free_hit_in;
      free_idx_ff   <= free_idx_in;
      best_hit_ff   <= best_hit_in;
      best_dist_ff  <= best_dist_in;
      best_tag_ff   <= best_tag_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_x_ff      <= rsp_x_in;
      rsp_y_ff      <= rsp_y_in;
   end

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_result_tag = rsp_tag_ff;
   assign rsp_result_x   = rsp_x_ff;
   assign rsp_result_y   = rsp_y_ff;

   // A result only follows a decision or the end of a nearest pass.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(state_ff) == ST_DECIDE || $past(state_ff) == ST_NEAR_DONE))
      else $error("result shown without a finished item");

   // A taken item makes the block busy in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("item taken but block not busy");

   // A successful add occupies exactly one more slot.
   assert property (@(posedge clock) disable iff (reset)
      ram_we |=> ($countones(valid_ff) == $past($countones(valid_ff)) + 1))
      else $error("add did not occupy one slot");

   // Entry checks only happen during a table walk.
   assert property (@(posedge clock) disable iff (reset)
      chk_vld_ff |-> (state_ff == ST_SCAN_KEY || state_ff == ST_SCAN_NEAR))
      else $error("entry check outside a table walk");

endmodule

### dv/axis_nearest_point_table_tb.sv
`timescale 1ns / 1ps

module axis_nearest_point_table_tb;
   import anpt_pkg::*;

   // One request to the point table, plus a flag that makes the sender wait
   // for every outstanding answer before it presents the item.
   typedef struct {
      logic [2:0]                   mode;
      logic [TAG_BITS-1:0]          tag;
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      logic [1:0]                   dir;
      bit                           drain_first;
   } request_type;

   // One answer as the block reports it.
   typedef struct {
      logic [2:0]                   status;
      logic                         found;
      logic [TAG_BITS-1:0]          tag;
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
   } answer_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         start = 1'b0;
   logic                         busy;
   logic [2:0]                   req_mode = '0;
   logic [TAG_BITS-1:0]          req_tower_tag = '0;
   logic signed [COORD_BITS-1:0] req_x_coord = '0;
   logic signed [COORD_BITS-1:0] req_y_coord = '0;
   logic [1:0]                   req_direction = '0;
   logic                         rsp_strobe;
   logic [2:0]                   rsp_status;
   logic                         rsp_found;
   logic [TAG_BITS-1:0]          rsp_result_tag;
   logic signed [COORD_BITS-1:0] rsp_result_x;
   logic signed [COORD_BITS-1:0] rsp_result_y;

   // Shadow copy of the point table.
   bit                           shadow_used [MAX_POINTS];
   logic [TAG_BITS-1:0]          shadow_tag  [MAX_POINTS];
   logic signed [COORD_BITS-1:0] shadow_x    [MAX_POINTS];
   logic signed [COORD_BITS-1:0] shadow_y    [MAX_POINTS];

   request_type queued_requests[$];
   answer_type  table_answers[$];
   request_type presented;
   int          error_count = 0;
   int          burst_left = 1;
   int          gap_left = 0;

   // Random requests draw from a small pool of tags and a small patch of the
   // grid so that lookups, collisions and neighbors are common.
   logic [TAG_BITS-1:0]          pool_tag_base;
   logic signed [COORD_BITS-1:0] patch_x_base;
   logic signed [COORD_BITS-1:0] patch_y_base;

   axis_nearest_point_table dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_mode       (req_mode),
      .req_tower_tag  (req_tower_tag),
      .req_x_coord    (req_x_coord),
      .req_y_coord    (req_y_coord),
      .req_direction  (req_direction),
      .rsp_strobe     (rsp_strobe),
      .rsp_status     (rsp_status),
      .rsp_found      (rsp_found),
      .rsp_result_tag (rsp_result_tag),
      .rsp_result_x   (rsp_result_x),
      .rsp_result_y   (rsp_result_y)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Slot holding a tag, or -1.
   function automatic int slot_of_tag(logic [TAG_BITS-1:0] tag);
      for (int i = 0; i < MAX_POINTS; i++) begin
         if (shadow_used[i] && shadow_tag[i] == tag) return i;
      end
      return -1;
   endfunction

   // Slot holding a cell, or -1.
   function automatic int slot_of_cell(logic signed [COORD_BITS-1:0] x,
                                       logic signed [COORD_BITS-1:0] y);
      for (int i = 0; i < MAX_POINTS; i++) begin
         if (shadow_used[i] && shadow_x[i] == x && shadow_y[i] == y) return i;
      end
      return -1;
   endfunction

   // Applies one request to the shadow table and returns the answer it must give.
   function automatic answer_type table_lookup(request_type rq);
      answer_type ans;
      int         s;
      int         best;
      int         best_dist;
      int         delta;
      ans = '{status: STATUS_OK, found: 1'b0, tag: '0, x: '0, y: '0};
      case (rq.mode)
         MODE_ADD: begin
            s = -1;
            if (slot_of_tag(rq.tag) >= 0) begin
               ans.status = STATUS_TAG_EXISTS;
            end else if (slot_of_cell(rq.x, rq.y) >= 0) begin
               ans.status = STATUS_CELL_OCCUPIED;
            end else begin
               for (int i = MAX_POINTS - 1; i >= 0; i--) begin
                  if (!shadow_used[i]) s = i;
               end
               if (s < 0) begin
                  ans.status = STATUS_TABLE_FULL;
               end else begin
                  shadow_used[s] = 1'b1;
                  shadow_tag[s]  = rq.tag;
                  shadow_x[s]    = rq.x;
                  shadow_y[s]    = rq.y;
               end
            end
         end
         MODE_REMOVE: begin
            s = slot_of_tag(rq.tag);
            if (s < 0) ans.status = STATUS_TAG_MISSING;
            else shadow_used[s] = 1'b0;
         end
         MODE_POSITION: begin
            s = slot_of_tag(rq.tag);
            if (s < 0) begin
               ans.status = STATUS_TAG_MISSING;
            end else begin
               ans.x = shadow_x[s];
               ans.y = shadow_y[s];
            end
         end
         MODE_CELL: begin
            s = slot_of_cell(rq.x, rq.y);
            if (s >= 0) begin
               ans.found = 1'b1;
               ans.tag   = shadow_tag[s];
            end
         end
         MODE_NEAREST: begin
            s = slot_of_tag(rq.tag);
            best = -1;
            best_dist = 0;
            if (s < 0) begin
               ans.status = STATUS_TAG_MISSING;
            end else begin
               // Only points on the same column or row and strictly beyond count.
               for (int i = 0; i < MAX_POINTS; i++) begin
                  delta = 0;
                  if (shadow_used[i] && i != s) begin
                     if (rq.dir == DIR_NORTH || rq.dir == DIR_SOUTH) begin
                        if (shadow_x[i] == shadow_x[s]) begin
                           delta = int'(shadow_y[i]) - int'(shadow_y[s]);
                           if (rq.dir == DIR_SOUTH) delta = -delta;
                        end
                     end else if (shadow_y[i] == shadow_y[s]) begin
                        delta = int'(shadow_x[i]) - int'(shadow_x[s]);
                        if (rq.dir == DIR_WEST) delta = -delta;
                     end
                  end
                  if (delta > 0 && (best < 0 || delta < best_dist)) begin
                     best = i;
                     best_dist = delta;
                  end
               end
               if (best < 0) ans.status = STATUS_NONE_IN_DIR;
               else ans.tag = shadow_tag[best];
            end
         end
         default: begin
            // Unused modes leave the table alone and answer all zero.
         end
      endcase
      return ans;
   endfunction

   task automatic push_request(logic [2:0] mode, logic [TAG_BITS-1:0] tag,
                               logic signed [COORD_BITS-1:0] x,
                               logic signed [COORD_BITS-1:0] y,
                               logic [1:0] dir, bit drain_first);
      request_type rq;
      rq = '{mode: mode, tag: tag, x: x, y: y, dir: dir, drain_first: drain_first};
      queued_requests.push_back(rq);
   endtask

   // Queues one random request; weights are percentages, the rest is nearest.
   task automatic push_random(int add_w, int remove_w, int pos_w, int cell_w);
      request_type rq;
      int          pick;
      rq.tag = pool_tag_base + TAG_BITS'($urandom_range(0, 127));
      rq.x   = patch_x_base + COORD_BITS'($urandom_range(0, 11));
      rq.y   = patch_y_base + COORD_BITS'($urandom_range(0, 11));
      rq.dir = 2'($urandom_range(0, 3));
      rq.drain_first = 1'b0;
      if ($urandom_range(0, 99) < 8) begin
         // Noise: any mode, any tag, anywhere on the grid.
         rq.mode = 3'($urandom_range(0, 7));
         rq.tag  = TAG_BITS'($urandom_range(0, 65535));
         rq.x    = COORD_BITS'($urandom_range(0, 65535));
         rq.y    = COORD_BITS'($urandom_range(0, 65535));
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < add_w) rq.mode = MODE_ADD;
         else if (pick < add_w + remove_w) rq.mode = MODE_REMOVE;
         else if (pick < add_w + remove_w + pos_w) rq.mode = MODE_POSITION;
         else if (pick < add_w + remove_w + pos_w + cell_w) rq.mode = MODE_CELL;
         else rq.mode = MODE_NEAREST;
      end
      queued_requests.push_back(rq);
   endtask

   // Sender: presents queued items in bursts with random gaps between them.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            table_answers.push_back(table_lookup(presented));
         end
         if (start && busy) begin
            // The item is still waiting to be taken; hold it.
         end else if (gap_left > 0) begin
            gap_left = gap_left - 1;
            start <= 1'b0;
         end else if (queued_requests.size() > 0 &&
                      !(queued_requests[0].drain_first && table_answers.size() > 0)) begin
            presented = queued_requests.pop_front();
            req_mode      <= presented.mode;
            req_tower_tag <= presented.tag;
            req_x_coord   <= presented.x;
            req_y_coord   <= presented.y;
            req_direction <= presented.dir;
            start         <= 1'b1;
            burst_left = burst_left - 1;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 8);
               case ($urandom_range(0, 2))
                  0: gap_left = 0;
                  1: gap_left = $urandom_range(1, 20);
                  default: gap_left = $urandom_range(20, 150);
               endcase
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected 0x%h, actual 0x%h", name, want, got);
         error_count++;
      end
   endfunction

   // Receiver: every strobed answer is checked against the oldest prediction.
   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp_strobe) begin
         if (table_answers.size() == 0) begin
            $error("unexpected answer: status 0x%h tag 0x%h", rsp_status, rsp_result_tag);
            error_count++;
         end else begin
            want = table_answers.pop_front();
            compare_field("status", 16'(want.status), 16'(rsp_status));
            compare_field("found", 16'(want.found), 16'(rsp_found));
            compare_field("result_tag", want.tag, rsp_result_tag);
            compare_field("result_x", want.x, rsp_result_x);
            compare_field("result_y", want.y, rsp_result_y);
         end
      end
   end

   initial begin
      pool_tag_base = TAG_BITS'($urandom_range(0, 65535));
      patch_x_base  = COORD_BITS'($urandom_range(0, 65535));
      patch_y_base  = COORD_BITS'($urandom_range(0, 65535));

      // Directed: lookups on an empty table.
      push_request(MODE_NEAREST, 16'h0005, 16'sd0, 16'sd0, DIR_NORTH, 1'b0);
      push_request(MODE_REMOVE, 16'h0005, 16'sd0, 16'sd0, DIR_SOUTH, 1'b0);
      push_request(MODE_POSITION, 16'h0005, 16'sd0, 16'sd0, DIR_EAST, 1'b0);
      push_request(MODE_CELL, 16'h0000, 16'sd0, 16'sd0, DIR_WEST, 1'b0);
      // Points at the far ends of one row, then duplicate tag and cell.
      push_request(MODE_ADD, 16'h0000, -16'sd32768, 16'sd0, DIR_NORTH, 1'b0);
      push_request(MODE_ADD, 16'hffff, 16'sd32767, 16'sd0, DIR_NORTH, 1'b0);
      push_request(MODE_ADD, 16'h0000, 16'sd1, 16'sd1, DIR_NORTH, 1'b0);
      push_request(MODE_ADD, 16'h0007, 16'sd32767, 16'sd0, DIR_NORTH, 1'b0);
      // Widest possible distance east and west, and empty directions.
      push_request(MODE_NEAREST, 16'h0000, 16'sd0, 16'sd0, DIR_EAST, 1'b0);
      push_request(MODE_NEAREST, 16'hffff, 16'sd0, 16'sd0, DIR_WEST, 1'b0);
      push_request(MODE_NEAREST, 16'h0000, 16'sd0, 16'sd0, DIR_WEST, 1'b0);
      push_request(MODE_NEAREST, 16'h0000, 16'sd0, 16'sd0, DIR_NORTH, 1'b0);
      // Column neighbors north and south, then a closer one to the north.
      push_request(MODE_ADD, 16'h1234, -16'sd32768, 16'sd32767, DIR_NORTH, 1'b0);
      push_request(MODE_ADD, 16'h4321, -16'sd32768, -16'sd32768, DIR_NORTH, 1'b0);
      push_request(MODE_NEAREST, 16'h0000, 16'sd0, 16'sd0, DIR_NORTH, 1'b0);
      push_request(MODE_NEAREST, 16'h0000, 16'sd0, 16'sd0, DIR_SOUTH, 1'b0);
      push_request(MODE_ADD, 16'h0100, -16'sd32768, 16'sd5, DIR_NORTH, 1'b0);
      push_request(MODE_NEAREST, 16'h0000, 16'sd0, 16'sd0, DIR_NORTH, 1'b0);
      push_request(MODE_POSITION, 16'hffff, 16'sd0, 16'sd0, DIR_NORTH, 1'b0);
      push_request(MODE_POSITION, 16'h4321, 16'sd0, 16'sd0, DIR_NORTH, 1'b0);
      push_request(MODE_CELL, 16'h0000, 16'sd32767, 16'sd0, DIR_NORTH, 1'b0);
      push_request(MODE_REMOVE, 16'hffff, 16'sd0, 16'sd0, DIR_NORTH, 1'b0);
      push_request(MODE_NEAREST, 16'h0000, 16'sd0, 16'sd0, DIR_EAST, 1'b0);
      // Unused modes with busy fields must answer all zero.
      push_request(3'd5, 16'hffff, -16'sd1, -16'sd1, DIR_WEST, 1'b0);
      push_request(3'd7, 16'h0000, 16'sd32767, -16'sd32768, DIR_WEST, 1'b0);

      // Random: fill the table past capacity, then churn it, then thin it out.
      repeat (220) push_random(80, 0, 7, 7);
      push_request(MODE_CELL, pool_tag_base, patch_x_base, patch_y_base, DIR_NORTH, 1'b1);
      repeat (199) push_random(20, 25, 15, 15);
      repeat (100) push_random(20, 35, 10, 10);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (queued_requests.size() > 0 || start) @(posedge clock);
      while (table_answers.size() > 0) @(posedge clock);
      repeat (2 * MAX_POINTS + 8) @(posedge clock);

      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule

### sim.f
rtl/anpt_pkg.sv
rtl/anpt_ram.sv
rtl/anpt_match.sv
rtl/axis_nearest_point_table.sv
dv/axis_nearest_point_table_tb.sv
